// File: hw/rtl/oaxy_pkg.sv
// Shared constants, quadrant codes and the arctangent table for the angle-to-xy pipeline.
package oaxy_pkg;

  // Fixed field widths
  localparam int ANGLE_W  = 24;
  localparam int RADIUS_W = 12;

  // Internal angle format: degrees with 20 fraction bits
  localparam int ANG_FRAC  = 20;
  localparam int T_W       = 27;
  localparam int Z_W       = T_W + 2;
  localparam int TABLE_LEN = 24;

  // Rotation datapath in Q30
  localparam int Q30_SHIFT = 30;
  localparam int XY_W      = 34;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

  // Reciprocal of 360 for the modulo stage
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 24;

  // Stage counts of the front and back ends
  localparam int WRAP_ST  = 4;
  localparam int SCALE_ST = 3;

  // Parameter defaults
  localparam int DEF_STAGES = 16;
  localparam int DEF_FRAC   = 8;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  // atan(2^-i) in degrees, scaled by 2^20, rounded to nearest
  function automatic logic [T_W-1:0] atan_deg(input int idx);
    logic [T_W-1:0] val;
    case (idx)
      0:       val = 27'd47185920;
      1:       val = 27'd27855475;
      2:       val = 27'd14718068;
      3:       val = 27'd7471121;
      4:       val = 27'd3750058;
      5:       val = 27'd1876857;
      6:       val = 27'd938658;
      7:       val = 27'd469357;
      8:       val = 27'd234682;
      9:       val = 27'd117342;
      10:      val = 27'd58671;
      11:      val = 27'd29335;
      12:      val = 27'd14668;
      13:      val = 27'd7334;
      14:      val = 27'd3667;
      15:      val = 27'd1833;
      16:      val = 27'd917;
      17:      val = 27'd458;
      18:      val = 27'd229;
      19:      val = 27'd115;
      20:      val = 27'd57;
      21:      val = 27'd29;
      22:      val = 27'd14;
      23:      val = 27'd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/oaxy_wrap.sv
// Front end: angle modulo 360 degrees and quadrant folding, four register stages.
module oaxy_wrap #(
  parameter int FRAC_BITS = oaxy_pkg::DEF_FRAC
) (
  input  logic                                 clk_i,
  input  logic [oaxy_pkg::WRAP_ST-1:0]         en_i,
  input  logic signed [oaxy_pkg::ANGLE_W-1:0]  angle_deg_i,
  input  logic [oaxy_pkg::RADIUS_W-1:0]        radius_i,
  output logic signed [oaxy_pkg::Z_W-1:0]      z_o,
  output oaxy_pkg::quad_e                      quad_o,
  output logic [8+FRAC_BITS:0]                 wrap_o,
  output logic [oaxy_pkg::RADIUS_W-1:0]        radius_o
);

  localparam int AW     = oaxy_pkg::ANGLE_W;
  localparam int RADW   = oaxy_pkg::RADIUS_W;
  localparam int RW     = oaxy_pkg::RECIP_W;
  localparam int RSH    = oaxy_pkg::RECIP_SHIFT;
  localparam int TW     = oaxy_pkg::T_W;
  localparam int VW     = AW - FRAC_BITS;
  localparam int PW     = VW + RW;
  localparam int WW     = 9 + FRAC_BITS;
  localparam int FULL   = 360 << FRAC_BITS;
  localparam int OFFSET = (1 << (AW - 1)) % FULL;
  localparam int FSH    = oaxy_pkg::ANG_FRAC - FRAC_BITS;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RSH) / 64'd360);
  localparam logic [WW-1:0] Q1 = WW'(90 << FRAC_BITS);
  localparam logic [WW-1:0] Q2 = WW'(180 << FRAC_BITS);
  localparam logic [WW-1:0] Q3 = WW'(270 << FRAC_BITS);

  // Stage 0: bias to unsigned, estimate quotient of the integer part by 360
  logic [AW-1:0]        ubias;
  logic [PW-1:0]        prod_d, prod_q;
  logic [VW-1:0]        v0_q;
  logic [FRAC_BITS-1:0] lo0_q;
  logic [RADW-1:0]      rad0_q;

  assign ubias  = {~angle_deg_i[AW-1], angle_deg_i[AW-2:0]};
  assign prod_d = PW'(ubias[AW-1:FRAC_BITS]) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      v0_q   <= ubias[AW-1:FRAC_BITS];
      lo0_q  <= ubias[FRAC_BITS-1:0];
      rad0_q <= radius_i;
    end
  end

  // Stage 1: remainder from the estimate, below twice 360
  logic [VW-1:0]        qmul, rem_full;
  logic [9:0]           r0_d, r0_q;
  logic [FRAC_BITS-1:0] lo1_q;
  logic [RADW-1:0]      rad1_q;

  assign qmul     = VW'(VW'(prod_q[PW-1:RSH]) * VW'(360));
  assign rem_full = v0_q - qmul;
  assign r0_d     = rem_full[9:0];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      r0_q   <= r0_d;
      lo1_q  <= lo0_q;
      rad1_q <= rad0_q;
    end
  end

  // Stage 2: correct the remainder and remove the bias
  logic [8:0]      r9;
  logic [WW-1:0]   rf, w_d, w2_q;
  logic [RADW-1:0] rad2_q;

  assign r9  = (r0_q >= 10'd360) ? 9'(r0_q - 10'd360) : r0_q[8:0];
  assign rf  = {r9, lo1_q};
  assign w_d = (rf >= WW'(OFFSET)) ? (rf - WW'(OFFSET)) : (rf + WW'(FULL - OFFSET));

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      w2_q   <= w_d;
      rad2_q <= rad1_q;
    end
  end

  // Stage 3: fold into a quadrant, turn by 270 degrees through the quadrant code
  logic [1:0]             qw;
  logic [WW-1:0]          base, tf;
  logic [TW-1:0]          t_d;
  logic signed [oaxy_pkg::Z_W-1:0] z_d, z_q;
  oaxy_pkg::quad_e        quad_d, quad_q;
  logic [WW-1:0]          w3_q;
  logic [RADW-1:0]        rad3_q;

  always_comb begin
    if (w2_q >= Q3) begin
      qw   = 2'd3;
      base = Q3;
    end else if (w2_q >= Q2) begin
      qw   = 2'd2;
      base = Q2;
    end else if (w2_q >= Q1) begin
      qw   = 2'd1;
      base = Q1;
    end else begin
      qw   = 2'd0;
      base = '0;
    end
  end

  assign tf     = w2_q - base;
  assign t_d    = TW'(tf) << FSH;
  assign z_d    = $signed({2'b00, t_d});
  assign quad_d = oaxy_pkg::quad_e'(qw + 2'd3);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      z_q    <= z_d;
      quad_q <= quad_d;
      w3_q   <= w2_q;
      rad3_q <= rad2_q;
    end
  end

  assign z_o      = z_q;
  assign quad_o   = quad_q;
  assign wrap_o   = w3_q;
  assign radius_o = rad3_q;

endmodule

// File: hw/rtl/oaxy_cordic_stage.sv
// One CORDIC rotation stage with a registered result and a carried sideband.
module oaxy_cordic_stage #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [oaxy_pkg::XY_W-1:0]   x_i,
  input  logic signed [oaxy_pkg::XY_W-1:0]   y_i,
  input  logic signed [oaxy_pkg::Z_W-1:0]    z_i,
  input  logic [SIDE_W-1:0]                  side_i,
  output logic signed [oaxy_pkg::XY_W-1:0]   x_o,
  output logic signed [oaxy_pkg::XY_W-1:0]   y_o,
  output logic signed [oaxy_pkg::Z_W-1:0]    z_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int XW = oaxy_pkg::XY_W;
  localparam int ZW = oaxy_pkg::Z_W;
  localparam logic [oaxy_pkg::T_W-1:0] ATAN_U = oaxy_pkg::atan_deg(IDX);
  localparam logic signed [ZW-1:0] ATAN = $signed({2'b00, ATAN_U});

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic [SIDE_W-1:0]    side_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// File: hw/rtl/oaxy_scale.sv
// Back end: quadrant rotation, radius multiply, rounding and saturation, three stages.
module oaxy_scale #(
  parameter int FRAC_BITS = oaxy_pkg::DEF_FRAC
) (
  input  logic                                       clk_i,
  input  logic [oaxy_pkg::SCALE_ST-1:0]              en_i,
  input  logic signed [oaxy_pkg::XY_W-1:0]           x_i,
  input  logic signed [oaxy_pkg::XY_W-1:0]           y_i,
  input  oaxy_pkg::quad_e                            quad_i,
  input  logic [8+FRAC_BITS:0]                       wrap_i,
  input  logic [oaxy_pkg::RADIUS_W-1:0]              radius_i,
  output logic [8+FRAC_BITS:0]                       wrapped_angle_o,
  output logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0] pos_x_o,
  output logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0] pos_y_o
);

  localparam int XW   = oaxy_pkg::XY_W;
  localparam int RADW = oaxy_pkg::RADIUS_W;
  localparam int WW   = 9 + FRAC_BITS;
  localparam int OW   = RADW + FRAC_BITS + 1;
  localparam int PRW  = XW + RADW + 1;
  localparam int SH   = oaxy_pkg::Q30_SHIFT - FRAC_BITS;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (SH - 1);

  // Stage 0: rotate the pair by whole quadrants
  logic signed [XW-1:0] c_d, s_d, c_q, s_q;
  logic [WW-1:0]        w0_q;
  logic [RADW-1:0]      rad0_q;

  always_comb begin
    case (quad_i)
      oaxy_pkg::QUAD_0: begin
        c_d = x_i;
        s_d = y_i;
      end
      oaxy_pkg::QUAD_90: begin
        c_d = -y_i;
        s_d = x_i;
      end
      oaxy_pkg::QUAD_180: begin
        c_d = -x_i;
        s_d = -y_i;
      end
      oaxy_pkg::QUAD_270: begin
        c_d = y_i;
        s_d = -x_i;
      end
      default: begin
        c_d = x_i;
        s_d = y_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c_q    <= c_d;
      s_q    <= s_d;
      w0_q   <= wrap_i;
      rad0_q <= radius_i;
    end
  end

  // Stage 1: scale by the radius
  logic signed [PRW-1:0] rad_s, pc_d, ps_d, pc_q, ps_q;
  logic [WW-1:0]         w1_q;
  logic [RADW-1:0]       rad1_q;

  assign rad_s = $signed(PRW'(rad0_q));
  assign pc_d  = rad_s * PRW'(c_q);
  assign ps_d  = rad_s * PRW'(s_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pc_q   <= pc_d;
      ps_q   <= ps_d;
      w1_q   <= w0_q;
      rad1_q <= rad0_q;
    end
  end

  // Stage 2: round half up, clip to the radius
  logic signed [PRW-1:0] lim, rc, rs, cc, cs;
  logic signed [OW-1:0]  px_q, py_q;
  logic [WW-1:0]         w2_q;

  assign lim = $signed(PRW'({rad1_q, {FRAC_BITS{1'b0}}}));
  assign rc  = (pc_q + HALF) >>> SH;
  assign rs  = (ps_q + HALF) >>> SH;

  always_comb begin
    if (rc > lim) begin
      cc = lim;
    end else if (rc < -lim) begin
      cc = -lim;
    end else begin
      cc = rc;
    end
    if (rs > lim) begin
      cs = lim;
    end else if (rs < -lim) begin
      cs = -lim;
    end else begin
      cs = rs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      px_q <= OW'(cc);
      py_q <= OW'(cs);
      w2_q <= w1_q;
    end
  end

  assign wrapped_angle_o = w2_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;

endmodule

// File: hw/rtl/orbit_angle_to_xy.sv
// Top level: pipelined polar-to-rectangular conversion of an orbit angle and radius.
//
// Input channel (in_valid_i / in_ready_o) carries a request: an angle in degrees,
// signed with FRAC_BITS fraction bits, and a radius in whole pixels. Output channel
// (out_valid_o / out_ready_i) returns the angle wrapped into [0, 360) degrees and
// x = radius * cos, y = radius * sin of that angle plus 270 degrees, so that zero
// points to 12 o'clock, both with FRAC_BITS fraction bits.
// Every request gives exactly one result, in order; nothing is kept between requests.
// Pipeline: four modulo/fold stages, one register stage per CORDIC rotation,
// and three stages for quadrant rotation, multiply and rounding.
// Throughput: one request per cycle while out_ready_i is high.
// Stall: each stage holds when it is full and the stage after it holds; empty
// stages keep filling, so requests are still taken while a result waits, until
// every stage is full. in_ready_o is high whenever out_valid_o is low or
// out_ready_i is high.
// Reset clears all valid bits; the pipeline is empty and ready right after it.
module orbit_angle_to_xy #(
  parameter int CORDIC_STAGES = oaxy_pkg::DEF_STAGES,
  parameter int FRAC_BITS     = oaxy_pkg::DEF_FRAC
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic signed [oaxy_pkg::ANGLE_W-1:0]           angle_deg_i,
  input  logic [oaxy_pkg::RADIUS_W-1:0]                 orbit_radius_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [8+FRAC_BITS:0]                          wrapped_angle_o,
  output logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0]  pos_x_o,
  output logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0]  pos_y_o
);

  localparam int WST    = oaxy_pkg::WRAP_ST;
  localparam int SST    = oaxy_pkg::SCALE_ST;
  localparam int NS     = WST + CORDIC_STAGES + SST;
  localparam int XW     = oaxy_pkg::XY_W;
  localparam int ZW     = oaxy_pkg::Z_W;
  localparam int RADW   = oaxy_pkg::RADIUS_W;
  localparam int WW     = 9 + FRAC_BITS;
  localparam int SIDE_W = WW + 2 + RADW;

  // Stage enables: a stage loads unless it and every stage after it are full
  // and the output is stalled
  logic [NS-1:0] valid_q, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = out_ready_i | ~&((valid_q >> k) | ~({NS{1'b1}} >> k));
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  // Front end
  logic signed [ZW-1:0] z0;
  oaxy_pkg::quad_e      quad0;
  logic [WW-1:0]        wrap0;
  logic [RADW-1:0]      rad0;

  oaxy_wrap #(
    .FRAC_BITS (FRAC_BITS)
  ) u_wrap (
    .clk_i       (clk_i),
    .en_i        (en[WST-1:0]),
    .angle_deg_i (angle_deg_i),
    .radius_i    (orbit_radius_i),
    .z_o         (z0),
    .quad_o      (quad0),
    .wrap_o      (wrap0),
    .radius_o    (rad0)
  );

  // Rotation stages
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  logic [SIDE_W-1:0]    cs [CORDIC_STAGES+1];

  assign cx[0] = oaxy_pkg::GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign cs[0] = {wrap0, quad0, rad0};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    oaxy_cordic_stage #(
      .IDX    (i),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (en[WST+i]),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .z_i    (cz[i]),
      .side_i (cs[i]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .z_o    (cz[i+1]),
      .side_o (cs[i+1])
    );
  end

  // Back end
  logic [SIDE_W-1:0]  side_end;
  oaxy_pkg::quad_e    quad_end;

  assign side_end     = cs[CORDIC_STAGES];
  assign quad_end     = oaxy_pkg::quad_e'(side_end[RADW+1:RADW]);

  oaxy_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i           (clk_i),
    .en_i            (en[NS-1:NS-SST]),
    .x_i             (cx[CORDIC_STAGES]),
    .y_i             (cy[CORDIC_STAGES]),
    .quad_i          (quad_end),
    .wrap_i          (side_end[SIDE_W-1:RADW+2]),
    .radius_i        (side_end[RADW-1:0]),
    .wrapped_angle_o (wrapped_angle_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o)
  );

endmodule

// File: hw/rtl/oaxy_checker.sv
// Port-level checker for the angle-to-xy pipeline, bound to the top level.
module oaxy_checker #(
  parameter int FRAC_BITS = oaxy_pkg::DEF_FRAC
) (
  input logic                                          clk_i,
  input logic                                          rst_ni,
  input logic                                          in_valid_i,
  input logic                                          in_ready_o,
  input logic signed [oaxy_pkg::ANGLE_W-1:0]           angle_deg_i,
  input logic [oaxy_pkg::RADIUS_W-1:0]                 orbit_radius_i,
  input logic                                          out_valid_o,
  input logic                                          out_ready_i,
  input logic [8+FRAC_BITS:0]                          wrapped_angle_o,
  input logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0]  pos_x_o,
  input logic signed [oaxy_pkg::RADIUS_W+FRAC_BITS:0]  pos_y_o
);

  localparam int FULL = 360 << FRAC_BITS;
  localparam int LIM  = ((1 << oaxy_pkg::RADIUS_W) - 1) << FRAC_BITS;

  // A stalled request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(angle_deg_i)
      && $stable(orbit_radius_i))
    else $error("input request dropped or changed while stalled");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(wrapped_angle_o)
      && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("result dropped or changed while stalled");

  // The pipeline takes a request whenever the output stage can drain
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with a free output stage");

  // Wrapped angle lies below 360 degrees
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(wrapped_angle_o) < FULL))
    else $error("wrapped angle out of range");

  // Coordinates stay within the largest radius
  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(pos_x_o) <= LIM) && (int'(pos_x_o) >= -LIM)
      && (int'(pos_y_o) <= LIM) && (int'(pos_y_o) >= -LIM))
    else $error("coordinate beyond the radius limit");

endmodule

bind orbit_angle_to_xy oaxy_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_oaxy_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .angle_deg_i     (angle_deg_i),
  .orbit_radius_i  (orbit_radius_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .wrapped_angle_o (wrapped_angle_o),
  .pos_x_o         (pos_x_o),
  .pos_y_o         (pos_y_o)
);
